// ===== rtl/utf8_to_code_point_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared property macros for the decoder's port checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODE_POINT_DECODER_DEFINES_SVH
`define UTF8_TO_CODE_POINT_DECODER_DEFINES_SVH

// Implication checked only outside reset
`define U2C_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked only outside reset
`define U2C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every edge, reset included
`define U2C_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/u2c_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Widths, masks and the lead byte classifier shared by the decoder modules.
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CpW      = 31;
  localparam int unsigned PendW    = 3;
  localparam int unsigned ContBits = 6;
  localparam int unsigned TdataOutW = 32;

  localparam logic [ByteW-1:0] ContMask = 8'h3F;
  localparam logic [ByteW-1:0] Lead2Mask = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Mask = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Mask = 8'h07;
  localparam logic [ByteW-1:0] Lead5Mask = 8'h03;
  localparam logic [ByteW-1:0] Lead6Mask = 8'h01;

  // One decoded result
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           bad_lead;
  } u2c_result_t;

  // Outcome of looking at a byte while no sequence is open
  typedef struct packed {
    logic             emit;     // result right away (ASCII or bad lead)
    logic             bad;      // byte cannot start a sequence
    logic [PendW-1:0] pending;  // continuation bytes to follow
    logic [ByteW-1:0] payload;  // lead payload bits or ASCII value
  } u2c_lead_t;

  function automatic u2c_lead_t classify_lead(input logic [ByteW-1:0] b);
    u2c_lead_t r;
    r = '0;
    unique casez (b)
      8'b0???_????: begin r.emit = 1'b1; r.payload = b; end
      8'b110?_????: begin r.pending = 3'd1; r.payload = b & Lead2Mask; end
      8'b1110_????: begin r.pending = 3'd2; r.payload = b & Lead3Mask; end
      8'b1111_0???: begin r.pending = 3'd3; r.payload = b & Lead4Mask; end
      8'b1111_10??: begin r.pending = 3'd4; r.payload = b & Lead5Mask; end
      8'b1111_110?: begin r.pending = 3'd5; r.payload = b & Lead6Mask; end
      default:      begin r.emit = 1'b1; r.bad = 1'b1; end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/utf8_to_code_point_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to code point decoder
// Decodes legacy UTF-8 (1 to 6 byte sequences) into 31-bit code points.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless the output stalls, and emits a code
// point after the last byte of each sequence (ASCII at once). After its
// last byte is accepted, a result moves from the input register through
// the combinational decode logic into the result register. The input side
// stalls only when both registers are full and the sink holds tready low.
// Continuation bytes are not checked; a byte that cannot open a sequence
// yields code point 0 with tuser set, and the next byte is again a lead.
module utf8_to_code_point_decoder import u2c_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ByteW-1:0]     s_axis_tdata,   // [7:0] in_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataOutW-1:0] m_axis_tdata,   // [30:0] code_point, [31] zero
  output logic                 m_axis_tuser    // [0] bad_lead
);

  logic             in_valid;
  logic             advance;
  logic             out_free;
  logic             emit;
  logic [ByteW-1:0] in_byte;
  u2c_result_t      dec_result;
  u2c_result_t      out_result;

  assign advance = in_valid && out_free;

  u2c_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .valid_o (in_valid),
    .take_i  (advance),
    .byte_o  (in_byte)
  );

  u2c_decode u_dec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte),
    .emit_o   (emit),
    .result_o (dec_result)
  );

  u2c_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (emit),
    .result_i (dec_result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {{(TdataOutW-CpW){1'b0}}, out_result.code_point};
  assign m_axis_tuser = out_result.bad_lead;

endmodule

// ===== rtl/u2c_in_stage.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder input stage
// Registers one incoming byte; refills in the same cycle it drains.
// ----------------------------------------------------------------------------
module u2c_in_stage import u2c_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [ByteW-1:0] byte_i,
  output logic             valid_o,
  input  logic             take_i,
  output logic [ByteW-1:0] byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/u2c_decode.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder core
// Holds the open-sequence state and turns one byte into zero or one result.
// ----------------------------------------------------------------------------
module u2c_decode import u2c_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             emit_o,
  output u2c_result_t      result_o
);

  logic [CpW-1:0]   partial_q, partial_d;
  logic [PendW-1:0] pending_q, pending_d;
  logic [CpW-1:0]   shifted;
  u2c_lead_t        lead;

  assign shifted = {partial_q[CpW-ContBits-1:0], byte_i[ContBits-1:0]};
  assign lead    = classify_lead(byte_i);

  // Next state and result
  always_comb begin
    partial_d = partial_q;
    pending_d = pending_q;
    emit_o    = 1'b0;
    result_o  = '0;
    if (step_i) begin
      if (pending_q != '0) begin
        pending_d = pending_q - 3'd1;
        if (pending_q == 3'd1) begin
          // last continuation byte closes the sequence
          emit_o              = 1'b1;
          result_o.code_point = shifted;
          partial_d           = '0;
        end else begin
          partial_d = shifted;
        end
      end else if (lead.emit) begin
        emit_o              = 1'b1;
        result_o.bad_lead   = lead.bad;
        result_o.code_point = lead.bad ? '0 : {{(CpW-ByteW){1'b0}}, lead.payload};
      end else begin
        pending_d = lead.pending;
        partial_d = {{(CpW-ByteW){1'b0}}, lead.payload};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      pending_q <= '0;
    end else begin
      partial_q <= partial_d;
      pending_q <= pending_d;
    end
  end

endmodule

// ===== rtl/u2c_out_stage.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder output stage
// Result register that holds a word until the sink takes it.
// ----------------------------------------------------------------------------
module u2c_out_stage import u2c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  u2c_result_t result_i,
  output logic        free_o,
  output logic        valid_o,
  input  logic        ready_i,
  output u2c_result_t result_o
);

  logic        valid_q, valid_d;
  u2c_result_t result_q;

  // Free when empty or draining this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== rtl/u2c_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the decoder's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_code_point_decoder_defines.svh"

module u2c_checker import u2c_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [ByteW-1:0]     s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [TdataOutW-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  // A reset edge leaves the result register empty
  `U2C_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni, !m_axis_tvalid, "output valid in reset")

  // Input backpressure only while a result waits at the output
  `U2C_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

  // Error results carry code point zero, and code points fit 31 bits
  `U2C_ASSERT_IMP(a_bad_zero, clk_i, rst_ni, m_axis_tvalid, (!m_axis_tuser || m_axis_tdata == '0) && !m_axis_tdata[TdataOutW-1], "bad result with nonzero data")

  // A stalled result holds
  `U2C_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // A byte offered but not taken stays on the input
  `U2C_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, s_axis_tvalid && !s_axis_tready, s_axis_tvalid && $stable(s_axis_tdata), "stalled input byte changed")

endmodule

bind utf8_to_code_point_decoder u2c_checker u_u2c_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
